/* rtl/fcst_pkg.sv */
package fcst_pkg;

    localparam int CAPACITY_ENTRIES = 32;
    localparam int VALUE_WIDTH      = 32;

    // count must hold 0..CAPACITY_ENTRIES
    localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);

    localparam int ACTION_W   = 2;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W   = 2;
    localparam int SIZE_W     = 6;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic start;      // launch the search token, clear hit marks
        logic load_tail;  // first free cell takes the key
        logic shift;      // cells at or past the hit take the right neighbor
    } fcst_ctrl_t;

endpackage

/* rtl/fcst_cell.sv */
module fcst_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcst_pkg::fcst_ctrl_t              ctrl,
    input  logic [fcst_pkg::VALUE_WIDTH-1:0]  key,
    input  logic                              active,
    input  logic                              tail,
    input  logic                              tok_in,
    input  logic                              hit_in,
    input  logic [fcst_pkg::VALUE_WIDTH-1:0]  right_value,
    output logic                              tok_out,
    output logic                              hit_out,
    output logic [fcst_pkg::VALUE_WIDTH-1:0]  value_out
);
    import fcst_pkg::*;

    logic                   tok_reg;
    logic                   hit_reg;
    logic                   hit_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   match;

    assign match = tok_reg && active && (value_reg == key);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.start)
        begin
            hit_next = 1'b0;
        end
        else if (tok_reg)
        begin
            // hit mark covers this cell and everything to its right
            hit_next = hit_in | match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_tail && tail)
        begin
            value_reg <= key;
        end
        else if (ctrl.shift && hit_reg)
        begin
            // close the hole left by an erase
            value_reg <= right_value;
        end
    end

    assign tok_out   = tok_reg;
    assign hit_out   = hit_reg;
    assign value_out = value_reg;

endmodule

/* rtl/fixed_capacity_set_table.sv */
// Channel | Direction | Handshake           | Word
// in      | to block  | in_valid / in_stall   | action, value
// out     | from block| out_valid / out_stall | status, present, size
//
// One request runs through a search, an update and an emit state: a search
// token walks the cell row one cell per cycle, then the update state decides
// the outcome and the emit state hands the result to the output register.
// Reset empties the set; cell contents stay undefined until written.
// A waiting result does not block the next request; out_stall only holds the
// block once a second result is ready behind it.
module fixed_capacity_set_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fcst_pkg::ACTION_W-1:0]   action,
    input  logic [fcst_pkg::VALUE_IN_W-1:0] value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fcst_pkg::STATUS_W-1:0]   status,
    output logic                            present,
    output logic [fcst_pkg::SIZE_W-1:0]     size
);
    import fcst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [ACTION_W-1:0]    action_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [STATUS_W-1:0]    res_status_next;
    logic                   res_present_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_present_reg;
    logic [SIZE_W-1:0]      out_size_reg;

    logic                   accept;
    logic                   found;
    fcst_ctrl_t             ctrl;

    logic [VALUE_IN_W+VALUE_WIDTH-1:0] value_ext;
    logic [VALUE_WIDTH-1:0]            key_next;
    logic [CNT_W+SIZE_W-1:0]           count_ext;

    logic [CAPACITY_ENTRIES:0]   tok;
    logic [CAPACITY_ENTRIES:0]   hit;
    logic [CAPACITY_ENTRIES-1:0] active;
    logic [CAPACITY_ENTRIES-1:0] tail;
    logic [VALUE_WIDTH-1:0]      cell_value [CAPACITY_ENTRIES];

    assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
    assign key_next  = value_ext[VALUE_WIDTH-1:0];
    assign count_ext = {{SIZE_W{1'b0}}, count_reg};

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign tok[0] = ctrl.start;
    assign hit[0] = 1'b0;
    assign found  = hit[CAPACITY_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY_ENTRIES; gi++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] right_value;

            assign active[gi] = (count_reg > CNT_W'(gi));
            assign tail[gi]   = (count_reg == CNT_W'(gi));

            if (gi == CAPACITY_ENTRIES - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign right_value = cell_value[gi+1];
            end

            fcst_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key         (key_reg),
                .active      (active[gi]),
                .tail        (tail[gi]),
                .tok_in      (tok[gi]),
                .hit_in      (hit[gi]),
                .right_value (right_value),
                .tok_out     (tok[gi+1]),
                .hit_out     (hit[gi+1]),
                .value_out   (cell_value[gi])
            );
        end
    endgenerate

    // decide the outcome once the token has left the last cell
    always_comb
    begin
        ctrl            = '0;
        ctrl.start      = accept;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        if (state_reg == S_UPDATE)
        begin
            case (action_reg)
                ACT_INSERT:
                begin
                    if (found)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else if (count_reg >= CNT_W'(CAPACITY_ENTRIES))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        res_status_next = ST_DONE;
                        ctrl.load_tail  = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                ACT_ERASE:
                begin
                    if (found)
                    begin
                        res_status_next = ST_DONE;
                        ctrl.shift      = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    res_status_next = found ? ST_DONE : ST_NOTFOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            action_reg      <= ACT_QUERY;
            key_reg         <= '0;
            count_reg       <= '0;
            res_status_reg  <= ST_DONE;
            res_present_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_DONE;
            out_present_reg <= 1'b0;
            out_size_reg    <= '0;
        end
        else
        begin
            // drop the word once taken, unless a new one replaces it this cycle
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg <= action;
                        key_reg    <= key_next;
                        state_reg  <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (tok[CAPACITY_ENTRIES])
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    count_reg       <= count_next;
                    res_status_reg  <= res_status_next;
                    res_present_reg <= found;
                    state_reg       <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold until the output register frees up
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= res_status_reg;
                        out_present_reg <= res_present_reg;
                        out_size_reg    <= count_ext[SIZE_W-1:0];
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign present   = out_present_reg;
    assign size      = out_size_reg;

endmodule
